FILE: hdl/flc_pkg.sv
package flc_pkg;

    localparam int KERNEL_TAPS_DEF = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    // Result value width and its byte-padded bus width.
    localparam int OUT_BITS   = 36;
    localparam int OUT_DATA_W = 40;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_KERNEL = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;

    localparam logic OP_KERNEL = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic       k_we;
        logic       h_push;
        logic       h_zero;
        logic       h_clear;
        logic       acc_clr;
        logic       mac_issue;
        logic       out_load;
        logic       out_err;
        logic [1:0] out_status;
        logic       out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: hdl/flc_ctrl.sv
module flc_ctrl #(
    parameter int KERNEL_TAPS = flc_pkg::KERNEL_TAPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_op,
    input  logic                           in_last,
    output flc_pkg::dp_cmd_t               cmd,
    input  flc_pkg::dp_stat_t              stat,
    output logic [$clog2(KERNEL_TAPS)-1:0] tap,
    output logic [$clog2(KERNEL_TAPS)-1:0] kaddr
);

    localparam int AW = $clog2(KERNEL_TAPS);
    localparam int KW = $clog2(KERNEL_TAPS + 1);
    localparam logic [KW-1:0] TAPS_K = KW'(KERNEL_TAPS);
    localparam logic [KW-1:0] ONE_K  = KW'(1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ERR   = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_SHIFT = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [KW-1:0] wr_idx_reg, wr_idx_next;
    logic [KW-1:0] len_reg, len_next;
    logic          ready_reg, ready_next;
    logic [KW-1:0] tap_reg, tap_next;
    logic [KW-1:0] tail_reg, tail_next;
    logic          last_reg, last_next;
    logic [1:0]    err_reg, err_next;

    assign in_ready = (state_reg == S_IDLE);
    assign tap      = tap_reg[AW-1:0];
    assign kaddr    = wr_idx_reg[AW-1:0];

    always_comb
    begin
        state_next  = state_reg;
        wr_idx_next = wr_idx_reg;
        len_next    = len_reg;
        ready_next  = ready_reg;
        tap_next    = tap_reg;
        tail_next   = tail_reg;
        last_next   = last_reg;
        err_next    = err_reg;
        cmd         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == flc_pkg::OP_KERNEL)
                    begin
                        // A word at slot zero starts a new load over the old kernel.
                        if (wr_idx_reg == '0)
                        begin
                            ready_next = 1'b0;
                        end
                        // The index parks at full capacity once the load overflows.
                        if (wr_idx_reg != TAPS_K)
                        begin
                            cmd.k_we    = 1'b1;
                            wr_idx_next = wr_idx_reg + ONE_K;
                        end
                        if (in_last)
                        begin
                            wr_idx_next = '0;
                            if (wr_idx_reg == TAPS_K)
                            begin
                                len_next   = '0;
                                ready_next = 1'b0;
                                err_next   = flc_pkg::ST_TOO_LONG;
                                state_next = S_ERR;
                            end
                            else
                            begin
                                len_next    = wr_idx_reg + ONE_K;
                                ready_next  = 1'b1;
                                cmd.h_clear = 1'b1;
                            end
                        end
                    end
                    else if (!ready_reg || len_reg == '0)
                    begin
                        err_next   = flc_pkg::ST_NO_KERNEL;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        cmd.h_push  = 1'b1;
                        cmd.acc_clr = 1'b1;
                        tap_next    = '0;
                        last_next   = in_last;
                        tail_next   = in_last ? (len_reg - ONE_K) : '0;
                        state_next  = S_MAC;
                    end
                end
            end

            S_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_err    = 1'b1;
                    cmd.out_status = err_reg;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_MAC:
            begin
                cmd.mac_issue = 1'b1;
                if (tap_reg == len_reg - ONE_K)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + ONE_K;
                end
            end

            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = flc_pkg::ST_OK;
                    cmd.out_last   = last_reg && (tail_reg == '0);
                    if (tail_reg != '0)
                    begin
                        tail_next  = tail_reg - ONE_K;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        cmd.h_clear = last_reg;
                        state_next  = S_IDLE;
                    end
                end
            end

            S_SHIFT:
            begin
                // Tail outputs shift zeros through the history.
                cmd.h_push  = 1'b1;
                cmd.h_zero  = 1'b1;
                cmd.acc_clr = 1'b1;
                tap_next    = '0;
                state_next  = S_MAC;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wr_idx_reg <= '0;
            len_reg    <= '0;
            ready_reg  <= 1'b0;
            tap_reg    <= '0;
            tail_reg   <= '0;
            last_reg   <= 1'b0;
            err_reg    <= flc_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            wr_idx_reg <= wr_idx_next;
            len_reg    <= len_next;
            ready_reg  <= ready_next;
            tap_reg    <= tap_next;
            tail_reg   <= tail_next;
            last_reg   <= last_next;
            err_reg    <= err_next;
        end
    end

endmodule

FILE: hdl/flc_dp.sv
module flc_dp #(
    parameter int KERNEL_TAPS = flc_pkg::KERNEL_TAPS_DEF,
    parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  flc_pkg::dp_cmd_t                    cmd,
    output flc_pkg::dp_stat_t                   stat,
    input  logic [$clog2(KERNEL_TAPS)-1:0]      tap,
    input  logic [$clog2(KERNEL_TAPS)-1:0]      kaddr,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [flc_pkg::OUT_BITS-1:0] out_value,
    output logic [1:0]                          out_status,
    output logic                                out_last
);

    localparam int AW    = $clog2(KERNEL_TAPS);
    localparam int KW    = $clog2(KERNEL_TAPS + 1);
    localparam int PW    = 2 * SAMPLE_BITS;
    localparam int ACC_W = 2 * SAMPLE_BITS + $clog2(KERNEL_TAPS);
    localparam int OW    = flc_pkg::OUT_BITS;
    localparam int EW    = (ACC_W > OW) ? ACC_W : OW;

    localparam logic [AW-1:0] LAST_A  = AW'(KERNEL_TAPS - 1);
    localparam logic [AW-1:0] ONE_A   = AW'(1);
    localparam logic [AW:0]   TAPS_A1 = (AW + 1)'(KERNEL_TAPS);
    localparam logic [KW-1:0] TAPS_K  = KW'(KERNEL_TAPS);
    localparam logic [KW-1:0] ONE_K   = KW'(1);
    localparam logic signed [EW-1:0] OUT_MAX = {{(EW - OW + 1){1'b0}}, {(OW - 1){1'b1}}};
    localparam logic signed [EW-1:0] OUT_MIN = ~OUT_MAX;

    logic signed [SAMPLE_BITS-1:0] kmem [KERNEL_TAPS];
    logic signed [SAMPLE_BITS-1:0] hmem [KERNEL_TAPS];

    // History is a ring: wp_reg holds the newest sample, cnt_reg the live entries.
    logic [AW-1:0] wp_reg, wp_next;
    logic [KW-1:0] cnt_reg;
    logic [AW-1:0] h_raddr;
    logic [AW:0]   wrap_sum;
    logic          h_live;

    logic                          rd_v_reg;
    logic                          mul_v_reg;
    logic signed [SAMPLE_BITS-1:0] k_rd_reg;
    logic signed [SAMPLE_BITS-1:0] h_rd_reg;
    logic                          hv_reg;
    logic signed [SAMPLE_BITS-1:0] h_op;
    logic signed [PW-1:0]          prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [EW-1:0]          acc_ext;
    logic signed [OW-1:0]          sat_val;

    logic                 out_valid_reg;
    logic signed [OW-1:0] out_value_reg;
    logic [1:0]           out_status_reg;
    logic                 out_last_reg;

    assign wp_next  = (wp_reg == LAST_A) ? '0 : (wp_reg + ONE_A);
    assign wrap_sum = {1'b0, wp_reg} + TAPS_A1 - {1'b0, tap};
    assign h_raddr  = (wp_reg >= tap) ? (wp_reg - tap) : wrap_sum[AW-1:0];
    assign h_live   = (KW'(tap) < cnt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.k_we)
        begin
            kmem[kaddr] <= sample;
        end
        if (cmd.h_push)
        begin
            hmem[wp_next] <= cmd.h_zero ? '0 : sample;
        end
        if (cmd.mac_issue)
        begin
            k_rd_reg <= kmem[tap];
            h_rd_reg <= hmem[h_raddr];
            hv_reg   <= h_live;
        end
    end

    // Entries older than the last clear read as zero.
    assign h_op = hv_reg ? h_rd_reg : '0;

    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            prod_reg <= k_rd_reg * h_op;
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (mul_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc_ext = EW'(acc_reg);

    always_comb
    begin
        if (acc_ext > OUT_MAX)
        begin
            sat_val = OUT_MAX[OW-1:0];
        end
        else if (acc_ext < OUT_MIN)
        begin
            sat_val = OUT_MIN[OW-1:0];
        end
        else
        begin
            sat_val = acc_ext[OW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            cnt_reg       <= '0;
            rd_v_reg      <= 1'b0;
            mul_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg  <= cmd.mac_issue;
            mul_v_reg <= rd_v_reg;
            if (cmd.h_push)
            begin
                wp_reg <= wp_next;
            end
            if (cmd.h_clear)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.h_push && cnt_reg != TAPS_K)
            begin
                cnt_reg <= cnt_reg + ONE_K;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg  <= cmd.out_err ? '0 : sat_val;
            out_status_reg <= cmd.out_status;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign stat.pipe_busy = rd_v_reg || mul_v_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

FILE: hdl/full_linear_convolution.sv
// Kernel words are taken one per cycle while idle; only an overflowed load gives a word, an
// error word, as for a sample with no kernel loaded.
// For L taps a result passes through a multiply-accumulate over its L taps on one
// shared multiplier, a drain of the pipeline and an output load; no new word is taken
// until it is loaded. The last sample adds L - 1 tail words, each produced the same way.
// Reset (rst_n, asynchronous, active low) clears the history and unloads the kernel.
module full_linear_convolution #(
    parameter int KERNEL_TAPS = flc_pkg::KERNEL_TAPS_DEF,
    parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // sample_value
    input  logic                                  s_axis_tuser,  // opcode
    input  logic                                  s_axis_tlast,  // last_in
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [flc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // conv_value
    output logic [1:0]                            m_axis_tuser,  // status_code
    output logic                                  m_axis_tlast   // last_out
);

    localparam int AW  = $clog2(KERNEL_TAPS);
    localparam int PAD = flc_pkg::OUT_DATA_W - flc_pkg::OUT_BITS;

    flc_pkg::dp_cmd_t                    cmd;
    flc_pkg::dp_stat_t                   stat;
    logic [AW-1:0]                       tap;
    logic [AW-1:0]                       kaddr;
    logic signed [SAMPLE_BITS-1:0]       sample;
    logic signed [flc_pkg::OUT_BITS-1:0] conv_value;

    assign sample = s_axis_tdata[SAMPLE_BITS-1:0];

    flc_ctrl #(
        .KERNEL_TAPS(KERNEL_TAPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .in_last  (s_axis_tlast),
        .cmd      (cmd),
        .stat     (stat),
        .tap      (tap),
        .kaddr    (kaddr)
    );

    flc_dp #(
        .KERNEL_TAPS(KERNEL_TAPS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .tap        (tap),
        .kaddr      (kaddr),
        .sample     (sample),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (conv_value),
        .out_status (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {{PAD{1'b0}}, conv_value};

endmodule

FILE: hdl/flc_checker.sv
module flc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           s_axis_tuser,
    input logic                           s_axis_tlast,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [flc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]                     m_axis_tuser,
    input logic                           m_axis_tlast
);

    // An error word always closes its sequence and carries a zero value.
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != flc_pkg::ST_OK |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("error word without last or with nonzero data");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled output word changed");

    // Results are produced only after an input word has been taken and worked on.
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("output word appeared right after an input word");

    // Mid-kernel words are absorbed at full rate.
    a_kernel_rate: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == flc_pkg::OP_KERNEL && !s_axis_tlast
            |=> s_axis_tready)
        else $error("input stalled after a kernel word");

endmodule

bind full_linear_convolution flc_checker u_flc_checker (.*);

FILE: dv/tb_full_linear_convolution.sv
`timescale 1ns / 100ps

module tb_full_linear_convolution;

    localparam int TAPS       = flc_pkg::KERNEL_TAPS_DEF;
    localparam int IN_DATA_W  = ((flc_pkg::SAMPLE_BITS_DEF + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 65;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [flc_pkg::OUT_BITS-1:0] value;
        logic [1:0]                   status;
        logic                         last;
    } conv_word_t;

    // Tracks the kernel and sample history and queues the words the block must produce.
    class conv_scoreboard;
        logic signed [15:0] taps [TAPS];
        logic signed [15:0] history [TAPS];
        int unsigned        tap_count;
        int unsigned        write_slot;
        bit                 kernel_loaded;
        conv_word_t         expected_q [$];
        int unsigned        mismatches;

        function new();
            foreach (taps[i])
                taps[i] = '0;
            clear_history();
            tap_count = 0;
            write_slot = 0;
            kernel_loaded = 0;
            mismatches = 0;
        endfunction

        function void clear_history();
            foreach (history[i])
                history[i] = '0;
        endfunction

        function void push(longint value, logic [1:0] status, logic last);
            conv_word_t word;
            word.value = value[flc_pkg::OUT_BITS-1:0];
            word.status = status;
            word.last = last;
            expected_q.push_back(word);
        endfunction

        // Shifts one sample into the history and returns the saturated sum of products.
        function longint shift_and_sum(logic signed [15:0] sample);
            longint acc;
            longint top;
            acc = 0;
            top = (longint'(1) <<< (flc_pkg::OUT_BITS - 1)) - 1;
            for (int k = TAPS - 1; k > 0; k--)
                history[k] = history[k-1];
            history[0] = sample;
            for (int k = 0; k < tap_count; k++)
                acc += longint'(taps[k]) * longint'(history[k]);
            if (acc > top)
                acc = top;
            if (acc < -top - 1)
                acc = -top - 1;
            return acc;
        endfunction

        function void note_input(logic op, logic signed [15:0] value, logic last);
            if (op == flc_pkg::OP_KERNEL)
            begin
                if (write_slot == 0)
                    kernel_loaded = 0;
                if (write_slot < TAPS)
                begin
                    taps[write_slot] = value;
                    write_slot++;
                end
                else
                begin
                    write_slot = TAPS + 1;
                end
                if (last)
                begin
                    if (write_slot > TAPS)
                    begin
                        tap_count = 0;
                        kernel_loaded = 0;
                        push(0, flc_pkg::ST_TOO_LONG, 1'b1);
                    end
                    else
                    begin
                        tap_count = write_slot;
                        kernel_loaded = 1;
                        clear_history();
                    end
                    write_slot = 0;
                end
            end
            else if (!kernel_loaded || tap_count == 0)
            begin
                push(0, flc_pkg::ST_NO_KERNEL, 1'b1);
            end
            else
            begin
                push(shift_and_sum(value), flc_pkg::ST_OK, last && tap_count == 1);
                if (last)
                begin
                    // The tail flushes the history with zeros.
                    for (int t = 1; t < tap_count; t++)
                        push(shift_and_sum('0), flc_pkg::ST_OK, t + 1 == tap_count);
                    clear_history();
                end
            end
        endfunction

        function void check_result(logic [flc_pkg::OUT_BITS-1:0] value, logic [1:0] status,
                                   logic last);
            conv_word_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result word value=%h status=%0d last=%0b",
                             $realtime, value, status, last);
                return;
            end
            want = expected_q.pop_front();
            if (want.value !== value || want.status !== status || want.last !== last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result mismatch: expected value=%h status=%0d last=%0b,",
                              " got value=%h status=%0d last=%0b"},
                             $realtime, want.value, want.status, want.last,
                             value, status, last);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [IN_DATA_W-1:0]           s_axis_tdata = '0;   // sample_value
    logic                           s_axis_tuser = 1'b0; // opcode
    logic                           s_axis_tlast = 1'b0; // last_in
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [flc_pkg::OUT_DATA_W-1:0] m_axis_tdata;        // conv_value
    logic [1:0]                     m_axis_tuser;        // status_code
    logic                           m_axis_tlast;        // last_out

    conv_scoreboard sb = new();
    int  items_sent = 0;
    bit  tx_steady = 0;
    bit  rx_steady = 0;
    int  rx_hold = 0;

    full_linear_convolution dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int stall_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int tx_gap();
        if (tx_steady || $urandom_range(0, 1) == 0)
            return 0;
        return stall_len();
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 19))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int pick_taps();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 6);
        if (r < 93)
            return $urandom_range(7, 16);
        return $urandom_range(17, TAPS);
    endfunction

    always @(posedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            rx_steady <= !rx_steady;
        if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!rx_steady && $urandom_range(0, 99) < 30)
        begin
            rx_hold <= stall_len() - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tuser, s_axis_tdata[15:0], s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[flc_pkg::OUT_BITS-1:0], m_axis_tuser, m_axis_tlast);
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** full_linear_convolution: FAILED **");
        $finish;
    end

    // Holds tvalid high across back-to-back words; it is only lowered for a gap.
    task automatic send_word(logic op, logic [15:0] value, logic last);
        int gap;
        gap = tx_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= value;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic load_kernel(int len, bit full_scale);
        for (int i = 0; i < len; i++)
            send_word(flc_pkg::OP_KERNEL, full_scale ? 16'h8000 : pick_sample(), i == len - 1);
    endtask

    task automatic play_signal(int len, bit full_scale);
        for (int i = 0; i < len; i++)
            send_word(flc_pkg::OP_SAMPLE, full_scale ? 16'h8000 : pick_sample(), i == len - 1);
    endtask

    initial
    begin
        int r;
        int start_count;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Samples before any kernel is loaded.
        send_word(flc_pkg::OP_SAMPLE, 16'h1234, 1'b0);
        send_word(flc_pkg::OP_SAMPLE, 16'h8000, 1'b1);

        // Single-tap kernel: the sample that ends the signal is also the final word.
        send_word(flc_pkg::OP_KERNEL, 16'h8000, 1'b1);
        send_word(flc_pkg::OP_SAMPLE, 16'h7FFF, 1'b1);

        send_word(flc_pkg::OP_KERNEL, 16'h7FFF, 1'b0);
        send_word(flc_pkg::OP_KERNEL, 16'h8000, 1'b0);
        send_word(flc_pkg::OP_KERNEL, 16'h0001, 1'b1);
        send_word(flc_pkg::OP_SAMPLE, 16'h8000, 1'b0);
        send_word(flc_pkg::OP_SAMPLE, 16'h7FFF, 1'b0);
        send_word(flc_pkg::OP_SAMPLE, 16'h0000, 1'b0);
        send_word(flc_pkg::OP_SAMPLE, 16'hFFFF, 1'b1);

        // A new load unloads the old kernel as soon as its first word lands.
        send_word(flc_pkg::OP_KERNEL, 16'h5555, 1'b0);
        send_word(flc_pkg::OP_SAMPLE, 16'h2222, 1'b1);
        send_word(flc_pkg::OP_KERNEL, 16'hAAAA, 1'b1);
        send_word(flc_pkg::OP_SAMPLE, 16'h4321, 1'b0);
        send_word(flc_pkg::OP_SAMPLE, 16'hBCDE, 1'b1);

        // Overflowed load, then a sample that finds no kernel.
        load_kernel(TAPS + 2, 1'b0);
        send_word(flc_pkg::OP_SAMPLE, 16'h0F0F, 1'b1);

        // Full kernel at the most negative value drives the sum into saturation.
        load_kernel(TAPS, 1'b1);
        play_signal(TAPS, 1'b1);

        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            tx_steady = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                if (!sb.kernel_loaded || $urandom_range(0, 9) < 7)
                    load_kernel(pick_taps(), 1'b0);
                play_signal($urandom_range(1, 8), 1'b0);
            end
            else if (r < 83)
            begin
                load_kernel($urandom_range(TAPS + 1, TAPS + 3), 1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_word(1'($urandom_range(0, 1)), pick_sample(),
                              1'($urandom_range(0, 1)));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** full_linear_convolution: PASSED **");
        else
            $display("** full_linear_convolution: FAILED **");
        $finish;
    end

endmodule

FILE: full_linear_convolution.f
hdl/flc_pkg.sv
hdl/flc_ctrl.sv
hdl/flc_dp.sv
hdl/full_linear_convolution.sv
hdl/flc_checker.sv
dv/tb_full_linear_convolution.sv
